>>> sv/spcu_pkg.sv
// Package: shared types, codes and widths of the servo pulse command unit.
`timescale 1ns / 1ps
package spcu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_US  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_US   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_US   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD   = 3'd4;

  localparam logic [1:0] UNIT_STEPS = 2'd0;
  localparam logic [1:0] UNIT_US    = 2'd1;
  localparam logic [1:0] UNIT_PCT   = 2'd2;

  localparam logic [1:0] DIR_ABS = 2'd0;
  localparam logic [1:0] DIR_ADD = 2'd1;
  localparam logic [1:0] DIR_SUB = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAN = 2'd1;
  localparam logic [1:0] STATUS_BAD_WIDTH = 2'd2;

  localparam logic [15:0] PCT_DEN = 16'd10000;

  // Shared serial divider
  localparam int DIVIDEND_W = 34;
  localparam int DIVISOR_W  = 17;
  localparam int QUO_W      = 21;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_NUM,
    ST_Q_GO,
    ST_Q_WAIT,
    ST_PULSE,
    ST_SCALE,
    ST_T_GO,
    ST_T_WAIT,
    ST_DONE
  } state_e;

endpackage

>>> sv/spcu_if.sv
// Interfaces: command, result and configuration channels.
`timescale 1ns / 1ps
interface spcu_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  servo_index;
  logic [1:0]  unit;
  logic [1:0]  direction;
  logic [15:0] amount;
  modport source (output valid, servo_index, unit, direction, amount, input ready);
  modport sink   (input valid, servo_index, unit, direction, amount, output ready);
endinterface

interface spcu_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  channel;
  logic [11:0] on_count;
  logic [11:0] off_count;
  logic [1:0]  status;
  modport source (output valid, channel, on_count, off_count, status, input ready);
  modport sink   (input valid, channel, on_count, off_count, status, output ready);
endinterface

interface spcu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spcu_pkg::CFG_IDX_W-1:0]  index;
  logic [spcu_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/servo_pulse_command_unit.sv
// Top level: servo position command resolver with PWM count output.
//
//  channel | dir | carries                                  | accepted when
//  cmd_i   | in  | servo_index, unit, direction, amount     | valid && ready
//  res_o   | out | channel, on_count, off_count, status     | valid && ready
//  cfg_i   | in  | index, data (register write)             | valid && ready
//
// Sequence: a valid command's request is accepted in IDLE, then come four set-up
// steps (READ, MUL, NUM, Q_GO), two divisions on the shared serial divider with
// PULSE, SCALE and T_GO between them, and DONE, where the result is loaded. The
// next request is taken in the cycle the result is presented. A bad channel,
// malformed code or empty pulse range goes from IDLE to DONE; an out-of-range width
// goes from NUM to DONE. One command is worked on at a time.
// Reset: asynchronous, active low; the position store reads as zero through
// per-channel valid bits, cleared at once by reset. No clearing pass.
// Stalls: the result register holds until taken; a new request is accepted
// while it waits, and that request holds in its last step until the slot frees.
`timescale 1ns / 1ps
module servo_pulse_command_unit #(
  parameter int CHANNELS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  spcu_cmd_if.sink   cmd_i,
  spcu_res_if.source res_o,
  spcu_cfg_if.sink   cfg_i
);
  localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT = 4096 / CHANNELS;

  // Configuration registers
  logic [7:0]  prescale_q;
  logic [9:0]  step_us_q;
  logic [15:0] min_us_q;
  logic [15:0] max_us_q;
  logic        spread_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= 8'd121;
      step_us_q  <= 10'd5;
      min_us_q   <= 16'd500;
      max_us_q   <= 16'd2500;
      spread_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        spcu_pkg::CFG_PRESCALE: prescale_q <= cfg_i.data[7:0];
        spcu_pkg::CFG_STEP_US:  step_us_q  <= cfg_i.data[9:0];
        spcu_pkg::CFG_MIN_US:   min_us_q   <= cfg_i.data;
        spcu_pkg::CFG_MAX_US:   max_us_q   <= cfg_i.data;
        spcu_pkg::CFG_SPREAD:   spread_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Control
  spcu_pkg::state_e state_q, state_d;
  logic             cmd_acc;
  logic             res_free;
  logic             mem_we;
  logic             div_done;
  logic [spcu_pkg::QUO_W-1:0] div_quo;
  spcu_pkg::div_req_t div_req;

  // Request fields and work registers
  logic [7:0]  idx_q;
  logic [1:0]  unit_q;
  logic [1:0]  dir_q;
  logic [15:0] amt_q;
  logic [1:0]  status_q, status_d;
  logic [32:0] base_q;
  logic [25:0] us_q;
  logic [32:0] num_q;
  logic [16:0] q_q;
  logic [31:0] pulse_q;
  logic [20:0] t1_q;

  logic [15:0] span;
  logic [15:0] den;
  logic [16:0] f_rd;
  logic [45:0] x_w, num_w, lim_w;
  logic        num_ok;

  // Position store: one synchronous memory with a registered read
  logic [16:0] pos_mem [CHANNELS];
  logic [16:0] rd_q;
  logic [CHANNELS-1:0] vld_q;
  logic [IW-1:0] addr;

  assign addr = idx_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pos_mem[addr] <= q_q;
    end
    rd_q <= pos_mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[addr] <= 1'b1;
    end
  end

  assign f_rd    = vld_q[addr] ? rd_q : 17'd0;
  assign span    = max_us_q - min_us_q;
  assign den     = (unit_q == spcu_pkg::UNIT_PCT) ? spcu_pkg::PCT_DEN : span;
  assign cmd_acc = cmd_i.valid && cmd_i.ready;
  assign res_free = !res_o.valid || res_o.ready;

  // Resolve the target numerator and range-check it
  always_comb begin
    x_w = (unit_q == spcu_pkg::UNIT_STEPS) ? (46'(us_q) << 16) : (46'(amt_q) << 16);
    case (dir_q)
      spcu_pkg::DIR_ABS: num_w = (unit_q == spcu_pkg::UNIT_PCT) ? x_w :
                                 x_w - (46'(min_us_q) << 16);
      spcu_pkg::DIR_ADD: num_w = 46'(base_q) + x_w;
      default:           num_w = 46'(base_q) - x_w;
    endcase
    lim_w  = 46'(den) << 16;
    num_ok = !num_w[45] && (num_w <= lim_w);
  end

  // Early rejection on request
  always_comb begin
    status_d = spcu_pkg::STATUS_OK;
    if (32'(cmd_i.servo_index) >= 32'(CHANNELS)) begin
      status_d = spcu_pkg::STATUS_BAD_CHAN;
    end else if ((max_us_q <= min_us_q) || (cmd_i.unit > spcu_pkg::UNIT_PCT) ||
                 (cmd_i.direction > spcu_pkg::DIR_SUB)) begin
      status_d = spcu_pkg::STATUS_BAD_WIDTH;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spcu_pkg::ST_IDLE:   if (cmd_acc) begin
        state_d = (status_d == spcu_pkg::STATUS_OK) ? spcu_pkg::ST_READ : spcu_pkg::ST_DONE;
      end
      spcu_pkg::ST_READ:   state_d = spcu_pkg::ST_MUL;
      spcu_pkg::ST_MUL:    state_d = spcu_pkg::ST_NUM;
      spcu_pkg::ST_NUM:    state_d = num_ok ? spcu_pkg::ST_Q_GO : spcu_pkg::ST_DONE;
      spcu_pkg::ST_Q_GO:   state_d = spcu_pkg::ST_Q_WAIT;
      spcu_pkg::ST_Q_WAIT: if (div_done) begin
        state_d = spcu_pkg::ST_PULSE;
      end
      spcu_pkg::ST_PULSE:  state_d = spcu_pkg::ST_SCALE;
      spcu_pkg::ST_SCALE:  state_d = spcu_pkg::ST_T_GO;
      spcu_pkg::ST_T_GO:   state_d = spcu_pkg::ST_T_WAIT;
      spcu_pkg::ST_T_WAIT: if (div_done) begin
        state_d = spcu_pkg::ST_DONE;
      end
      spcu_pkg::ST_DONE:   if (res_free) begin
        state_d = spcu_pkg::ST_IDLE;
      end
      default:             state_d = spcu_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_i.ready      = 1'b0;
    mem_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {num_q, 1'b0} + spcu_pkg::DIVIDEND_W'(den);
    div_req.divisor  = {den, 1'b0};
    case (state_q)
      spcu_pkg::ST_IDLE:  cmd_i.ready = 1'b1;
      spcu_pkg::ST_Q_GO:  div_req.start = 1'b1;
      spcu_pkg::ST_PULSE: mem_we = 1'b1;
      spcu_pkg::ST_T_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = spcu_pkg::DIVIDEND_W'(t1_q);
        div_req.divisor  = spcu_pkg::DIVISOR_W'({1'b0, prescale_q} + 9'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spcu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: hold each stage's value for the next
  always_ff @(posedge clk_i) begin
    case (state_q)
      spcu_pkg::ST_IDLE: if (cmd_acc) begin
        idx_q    <= cmd_i.servo_index;
        unit_q   <= cmd_i.unit;
        dir_q    <= cmd_i.direction;
        amt_q    <= cmd_i.amount;
        status_q <= status_d;
      end
      spcu_pkg::ST_MUL: begin
        base_q <= 33'(f_rd) * 33'(den);
        us_q   <= 26'(amt_q) * 26'(step_us_q);
      end
      spcu_pkg::ST_NUM: begin
        num_q <= num_w[32:0];
        if (!num_ok) begin
          status_q <= spcu_pkg::STATUS_BAD_WIDTH;
        end
      end
      spcu_pkg::ST_Q_WAIT: if (div_done) begin
        q_q <= div_quo[16:0];
      end
      spcu_pkg::ST_PULSE: pulse_q <= 32'(q_q) * 32'(span) + {min_us_q, 16'd0};
      spcu_pkg::ST_SCALE: t1_q <= 21'((37'(pulse_q) * 37'd25) >> 16);
      default: ;
    endcase
  end

  spcu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Result register
  logic [11:0] on_w;
  logic        res_load;
  logic        res_valid_q;
  logic [5:0]  res_chan_q;
  logic [11:0] res_on_q, res_off_q;
  logic [1:0]  res_status_q;

  assign on_w     = spread_q ? 12'(32'(idx_q[IW-1:0]) * SLOT) : 12'd0;
  assign res_load = (state_q == spcu_pkg::ST_DONE) && res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_status_q <= status_q;
      res_chan_q   <= (status_q == spcu_pkg::STATUS_BAD_CHAN) ? 6'd0 : idx_q[5:0];
      res_on_q     <= (status_q == spcu_pkg::STATUS_OK) ? on_w : 12'd0;
      res_off_q    <= (status_q == spcu_pkg::STATUS_OK) ? on_w + div_quo[11:0] : 12'd0;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.channel   = res_chan_q;
  assign res_o.on_count  = res_on_q;
  assign res_o.off_count = res_off_q;
  assign res_o.status    = res_status_q;

  a_write_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> status_q == spcu_pkg::STATUS_OK) else $error("store written on error");
  a_err_counts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != spcu_pkg::STATUS_OK) |->
      (res_o.on_count == 12'd0 && res_o.off_count == 12'd0))
    else $error("error result carries counts");
  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == spcu_pkg::ST_Q_WAIT || state_q == spcu_pkg::ST_T_WAIT))
    else $error("divider finished outside a wait step");
endmodule

>>> sv/spcu_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module spcu_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spcu_pkg::div_req_t              req_i,
  output logic                            done_o,
  output logic [spcu_pkg::QUO_W-1:0]      quotient_o
);
  localparam int SH_W = spcu_pkg::DIVISOR_W + spcu_pkg::QUO_W - 1;
  localparam int CW   = $clog2(spcu_pkg::QUO_W + 1);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [spcu_pkg::DIVIDEND_W-1:0] rem_q, rem_d;
  logic [SH_W-1:0]                 dsh_q, dsh_d;
  logic [spcu_pkg::QUO_W-1:0]      quo_q, quo_d;
  logic                            fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    fits   = ({{(SH_W - spcu_pkg::DIVIDEND_W){1'b0}}, rem_q} >= dsh_q);
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(spcu_pkg::QUO_W);
      rem_d  = req_i.dividend;
      dsh_d  = {req_i.divisor, {(spcu_pkg::QUO_W-1){1'b0}}};
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - spcu_pkg::DIVIDEND_W'(dsh_q);
      end
      quo_d = {quo_q[spcu_pkg::QUO_W-2:0], fits};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
endmodule
